// File: rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// Line segment clipper package
// Shared widths, outcode bits, window type and the front/back transfer type.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int CW        = 16;            // coordinate width
    localparam int MAX_CLIPS = 4;
    localparam int CLIP_CW   = 3;             // holds 0..MAX_CLIPS
    localparam int DW        = CW + 1;        // difference width
    localparam int PW        = 2 * DW;        // product magnitude width
    localparam int QCAP_W    = CW + 2;        // quotient width, cap 2^(CW+1)
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    localparam logic [CW-1:0] RST_XMIN = 16'sd800;
    localparam logic [CW-1:0] RST_YMIN = 16'sd160;
    localparam logic [CW-1:0] RST_XMAX = 16'sd1280;
    localparam logic [CW-1:0] RST_YMAX = 16'sd640;

    localparam logic [1:0] REG_XMIN = 2'd0;
    localparam logic [1:0] REG_YMIN = 2'd1;
    localparam logic [1:0] REG_XMAX = 2'd2;
    localparam logic [1:0] REG_YMAX = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] xmin;
        logic signed [CW-1:0] ymin;
        logic signed [CW-1:0] xmax;
        logic signed [CW-1:0] ymax;
    } window_t;

    // classified segment handed from front to back
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [3:0]           c0;
        logic [3:0]           c1;
    } seg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } back_state_t;

    function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y,
                                           input window_t w);
        logic [3:0] c;
        c = 4'd0;
        if (x < w.xmin)
        begin
            c = c | OC_LEFT;
        end
        else if (x > w.xmax)
        begin
            c = c | OC_RIGHT;
        end
        if (y < w.ymin)
        begin
            c = c | OC_BOTTOM;
        end
        else if (y > w.ymax)
        begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/line_segment_clipper_top.sv
// ----------------------------------------------------------------------------
// Line segment clipper
// Cohen-Sutherland clipping of one segment against a configured window.
//
//   channel  dir  contents
//   s_axis   in   tdata = start_x, start_y, end_x, end_y
//   m_axis   out  tdata = clip_x0, clip_y0, clip_x1, clip_y1; tuser = accepted
//   apb      in   window_x_min/y_min/x_max/y_max at 0x0/0x4/0x8/0xC
//
// A segment passes take, test and done, plus for each edge clip a multiply,
// a divide, an update and a retest; at most 4 clips.
// The front queue holds two classified segments while the back works.
// Reset loads the default window; no clearing pass.
// A stalled result holds the back end; the front keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_clipper_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // clip_x0, clip_y0, clip_x1, clip_y1
    output logic             m_axis_tuser,   // accepted
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    lsc_pkg::window_t win_reg;
    logic             q_valid, q_ready;
    lsc_pkg::seg_t    q_seg;
    logic [1:0]       ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.xmin <= lsc_pkg::RST_XMIN;
            win_reg.ymin <= lsc_pkg::RST_YMIN;
            win_reg.xmax <= lsc_pkg::RST_XMAX;
            win_reg.ymax <= lsc_pkg::RST_YMAX;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                lsc_pkg::REG_XMIN: win_reg.xmin <= pwdata[15:0];
                lsc_pkg::REG_YMIN: win_reg.ymin <= pwdata[15:0];
                lsc_pkg::REG_XMAX: win_reg.xmax <= pwdata[15:0];
                lsc_pkg::REG_YMAX: win_reg.ymax <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            lsc_pkg::REG_XMIN: prdata = 32'(win_reg.xmin);
            lsc_pkg::REG_YMIN: prdata = 32'(win_reg.ymin);
            lsc_pkg::REG_XMAX: prdata = 32'(win_reg.xmax);
            lsc_pkg::REG_YMAX: prdata = 32'(win_reg.ymax);
            default:           prdata = '0;
        endcase
    end

    lsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_seg    (q_seg)
    );

    lsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_seg     (q_seg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_acc   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/lsc_front.sv
// ----------------------------------------------------------------------------
// Line segment clipper front end
// Accepts segments, computes both outcodes and pushes them into a 2-deep queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lsc_pkg::window_t     win,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [4*lsc_pkg::CW-1:0] in_data,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output lsc_pkg::seg_t             q_seg
);

    lsc_pkg::seg_t            mem_reg [lsc_pkg::QDEPTH];
    logic [lsc_pkg::QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [lsc_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    lsc_pkg::seg_t            seg_in;
    logic                     push, pop;

    always_comb
    begin
        seg_in.x0 = in_data[lsc_pkg::CW-1:0];
        seg_in.y0 = in_data[2*lsc_pkg::CW-1:lsc_pkg::CW];
        seg_in.x1 = in_data[3*lsc_pkg::CW-1:2*lsc_pkg::CW];
        seg_in.y1 = in_data[4*lsc_pkg::CW-1:3*lsc_pkg::CW];
        seg_in.c0 = lsc_pkg::outcode(seg_in.x0, seg_in.y0, win);
        seg_in.c1 = lsc_pkg::outcode(seg_in.x1, seg_in.y1, win);
    end

    assign in_ready = (cnt_reg != (lsc_pkg::QPTR_W+1)'(lsc_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_seg    = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (lsc_pkg::QPTR_W+1)'(push) - (lsc_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= seg_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lsc_div.sv
// ----------------------------------------------------------------------------
// Line segment clipper divider
// Restoring divide of a product magnitude, one quotient bit per cycle,
// quotient saturated at 2^(CW+1) as it forms.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lsc_pkg::PW-1:0]    dividend,
    input  wire logic [lsc_pkg::DW-1:0]    divisor,
    output logic                           done,
    output logic [lsc_pkg::QCAP_W-1:0]     quot
);

    localparam int CNT_W = $clog2(lsc_pkg::PW + 1);
    localparam logic [lsc_pkg::QCAP_W-1:0] QCAP = {1'b1, {(lsc_pkg::QCAP_W-1){1'b0}}};

    logic [lsc_pkg::PW-1:0]     num_reg;
    logic [lsc_pkg::DW:0]       rem_reg;
    logic [lsc_pkg::DW-1:0]     den_reg;
    logic [lsc_pkg::QCAP_W-1:0] q_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic [lsc_pkg::DW:0]       rem_sh;
    logic                       ge;
    logic [lsc_pkg::QCAP_W:0]   q_sh;

    always_comb
    begin
        rem_sh = {rem_reg[lsc_pkg::DW-1:0], num_reg[lsc_pkg::PW-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
        q_sh   = {q_reg, ge};
        // once above the cap, the quotient only grows, so clamp each step
        if (q_sh > {1'b0, QCAP})
        begin
            q_sh = {1'b0, QCAP};
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            num_reg <= {num_reg[lsc_pkg::PW-2:0], 1'b0};
            rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            q_reg   <= q_sh[lsc_pkg::QCAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(lsc_pkg::PW);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lsc_back.sv
// ----------------------------------------------------------------------------
// Line segment clipper back end
// Runs the outcode test/clip loop on one segment and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lsc_pkg::window_t      win,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire lsc_pkg::seg_t         q_seg,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [4*lsc_pkg::CW-1:0]   out_data,
    output logic                       out_acc
);

    localparam int CW = lsc_pkg::CW;
    localparam int DW = lsc_pkg::DW;
    localparam logic signed [DW+1:0] SMAX = (DW+2)'((1 << (CW-1)) - 1);
    localparam logic signed [DW+1:0] SMIN = -(DW+2)'(1 << (CW-1));

    lsc_pkg::back_state_t st_reg, st_next;
    lsc_pkg::seg_t        seg_reg, seg_next;
    logic [lsc_pkg::CLIP_CW-1:0] n_reg, n_next;
    logic                 acc_reg, acc_next;
    logic                 vld_reg, vld_next;
    logic [4*CW-1:0]      res_reg, res_next;

    // clip operands
    logic signed [DW-1:0] a_reg, b_reg, c_reg;
    logic signed [CW-1:0] base_reg, fix_reg;
    logic                 vert_reg, first_reg, neg_reg;
    logic [lsc_pkg::PW-1:0] prod_reg;
    logic                 ld_op, ld_prod, start_reg, div_done;
    logic [lsc_pkg::QCAP_W-1:0] quot;

    logic [3:0]           co;
    logic                 is_vert, use_first, degen;
    logic signed [CW-1:0] fixv, basev;
    logic signed [DW-1:0] av, bv, cv;
    logic [DW-1:0]        ma, mb;
    logic signed [DW+1:0] sum;
    logic signed [CW-1:0] newc;
    logic signed [CW-1:0] nx, ny;

    lsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (prod_reg),
        .divisor  (c_reg[DW-1] ? DW'(-c_reg) : DW'(c_reg)),
        .done     (div_done),
        .quot     (quot)
    );

    // choose edge for current outside endpoint
    always_comb
    begin
        use_first = (seg_reg.c0 != 4'd0);
        co        = use_first ? seg_reg.c0 : seg_reg.c1;
        is_vert   = (co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 4'd0;
        if (is_vert)
        begin
            fixv  = ((co & lsc_pkg::OC_TOP) != 4'd0) ? win.ymax : win.ymin;
            basev = seg_reg.x0;
            av    = DW'(seg_reg.x1) - DW'(seg_reg.x0);
            bv    = DW'(fixv) - DW'(seg_reg.y0);
            cv    = DW'(seg_reg.y1) - DW'(seg_reg.y0);
            degen = (seg_reg.y1 == seg_reg.y0);
        end
        else
        begin
            fixv  = ((co & lsc_pkg::OC_RIGHT) != 4'd0) ? win.xmax : win.xmin;
            basev = seg_reg.y0;
            av    = DW'(seg_reg.y1) - DW'(seg_reg.y0);
            bv    = DW'(fixv) - DW'(seg_reg.x0);
            cv    = DW'(seg_reg.x1) - DW'(seg_reg.x0);
            degen = (seg_reg.x1 == seg_reg.x0);
        end
    end

    always_comb
    begin
        ma = a_reg[DW-1] ? DW'(-a_reg) : DW'(a_reg);
        mb = b_reg[DW-1] ? DW'(-b_reg) : DW'(b_reg);
        if (neg_reg)
        begin
            sum = (DW+2)'(base_reg) - (DW+2)'(signed'({1'b0, quot}));
        end
        else
        begin
            sum = (DW+2)'(base_reg) + (DW+2)'(signed'({1'b0, quot}));
        end
        if (sum > SMAX)
        begin
            newc = CW'(SMAX);
        end
        else if (sum < SMIN)
        begin
            newc = CW'(SMIN);
        end
        else
        begin
            newc = CW'(sum);
        end
        nx = vert_reg ? newc : fix_reg;
        ny = vert_reg ? fix_reg : newc;
    end

    always_ff @(posedge clk)
    begin
        if (ld_op)
        begin
            a_reg     <= av;
            b_reg     <= bv;
            c_reg     <= cv;
            base_reg  <= basev;
            fix_reg   <= fixv;
            vert_reg  <= is_vert;
            first_reg <= use_first;
            neg_reg   <= (av[DW-1] != bv[DW-1]) != cv[DW-1];
        end
        if (ld_prod)
        begin
            prod_reg <= lsc_pkg::PW'(ma) * lsc_pkg::PW'(mb);
        end
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            lsc_pkg::ST_IDLE:
            begin
                if (q_valid && !vld_reg)
                begin
                    st_next = lsc_pkg::ST_TEST;
                end
            end
            lsc_pkg::ST_TEST:
            begin
                if ((seg_reg.c0 | seg_reg.c1) == 4'd0 || (seg_reg.c0 & seg_reg.c1) != 4'd0
                    || n_reg == lsc_pkg::CLIP_CW'(lsc_pkg::MAX_CLIPS) || degen)
                begin
                    st_next = lsc_pkg::ST_DONE;
                end
                else
                begin
                    st_next = lsc_pkg::ST_MUL;
                end
            end
            lsc_pkg::ST_MUL:  st_next = lsc_pkg::ST_DIV;
            lsc_pkg::ST_DIV:  st_next = div_done ? lsc_pkg::ST_UPD : lsc_pkg::ST_DIV;
            lsc_pkg::ST_UPD:  st_next = lsc_pkg::ST_TEST;
            lsc_pkg::ST_DONE: st_next = lsc_pkg::ST_IDLE;
            default:          st_next = lsc_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        q_ready   = 1'b0;
        ld_op     = 1'b0;
        ld_prod   = 1'b0;
        seg_next  = seg_reg;
        n_next    = n_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        vld_next  = vld_reg && !out_ready;
        unique case (st_reg)
            lsc_pkg::ST_IDLE:
            begin
                if (q_valid && !vld_reg)
                begin
                    q_ready  = 1'b1;
                    seg_next = q_seg;
                    n_next   = '0;
                end
            end
            lsc_pkg::ST_TEST: ld_op = 1'b1;
            lsc_pkg::ST_MUL:
            begin
                ld_prod = 1'b1;
            end
            lsc_pkg::ST_DIV: ;
            lsc_pkg::ST_UPD:
            begin
                n_next = n_reg + 1'b1;
                if (first_reg)
                begin
                    seg_next.x0 = nx;
                    seg_next.y0 = ny;
                    seg_next.c0 = lsc_pkg::outcode(nx, ny, win);
                end
                else
                begin
                    seg_next.x1 = nx;
                    seg_next.y1 = ny;
                    seg_next.c1 = lsc_pkg::outcode(nx, ny, win);
                end
            end
            lsc_pkg::ST_DONE:
            begin
                vld_next = 1'b1;
                acc_next = (seg_reg.c0 | seg_reg.c1) == 4'd0;
                res_next = acc_next ? {seg_reg.y1, seg_reg.x1, seg_reg.y0, seg_reg.x0} : '0;
            end
            default: ;
        endcase
    end

    // start_reg is registered from ST_MUL, so it rises with the new product; done
    // never overlaps start because start loads the step count with PW
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= (st_reg == lsc_pkg::ST_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        n_reg   <= n_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= lsc_pkg::ST_IDLE;
            vld_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = res_reg;
    assign out_acc   = acc_reg;

endmodule

`default_nettype wire

// File: rtl/lsc_checker.sv
// ----------------------------------------------------------------------------
// Line segment clipper port checker
// Port-level properties of the stream and register interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        pready
);

    // a rejected segment carries all-zero endpoints
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("rejected result with nonzero data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    // no two results back to back: each one needs at least a test pass
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("results too close");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind line_segment_clipper_top lsc_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Line segment clipper testbench
// Drives segments over the input stream, programs the clip window over APB,
// predicts each clipped segment with a Cohen-Sutherland model of its own and
// checks every result field against it. Random idling on both sides, except in one quiet phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
    } segment_t;

    typedef struct packed {
        logic        acc;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
    } clipped_t;

    typedef struct {
        segment_t seg;
        bit       typed;
        clipped_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    longint   win_xmin, win_ymin, win_xmax, win_ymax;
    clipped_t expected_clips[$];
    int       mismatches;
    int       checked;
    int       accepted_seen;
    int       cycles;
    bit       quiet_rx;
    bit       quiet_tx;

    line_segment_clipper_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout with %0d results outstanding", expected_clips.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic longint sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c = 4'd0;
        if (x < win_xmin)
            c |= lsc_pkg::OC_LEFT;
        else if (x > win_xmax)
            c |= lsc_pkg::OC_RIGHT;
        if (y < win_ymin)
            c |= lsc_pkg::OC_BOTTOM;
        else if (y > win_ymax)
            c |= lsc_pkg::OC_TOP;
        return c;
    endfunction

    // base + a*b/c, truncated toward zero; quotient capped at 2^17
    function automatic longint edge_cross(longint base, longint a, longint b, longint c);
        longint q;
        longint p;
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        q = p / (c < 0 ? -c : c);
        if (q > (64'sd1 << 17))
            q = 64'sd1 << 17;
        if (((a < 0) != (b < 0)) != (c < 0))
            return sat16(base - q);
        return sat16(base + q);
    endfunction

    function automatic clipped_t clip_segment(segment_t s);
        clipped_t r;
        longint x0, y0, x1, y1, nx, ny;
        logic [3:0] c0, c1, co;
        bit acc;
        x0 = longint'($signed(s.x0));
        y0 = longint'($signed(s.y0));
        x1 = longint'($signed(s.x1));
        y1 = longint'($signed(s.y1));
        c0 = region_code(x0, y0);
        c1 = region_code(x1, y1);
        acc = 0;
        for (int n = 0; n <= lsc_pkg::MAX_CLIPS; n++)
        begin
            if ((c0 | c1) == 0)
            begin
                acc = 1;
                break;
            end
            if ((c0 & c1) != 0 || n == lsc_pkg::MAX_CLIPS)
                break;
            co = (c0 != 0) ? c0 : c1;
            if ((co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 0)
            begin
                ny = ((co & lsc_pkg::OC_TOP) != 0) ? win_ymax : win_ymin;
                if (y1 == y0)
                    break;
                nx = edge_cross(x0, x1 - x0, ny - y0, y1 - y0);
            end
            else
            begin
                nx = ((co & lsc_pkg::OC_RIGHT) != 0) ? win_xmax : win_xmin;
                if (x1 == x0)
                    break;
                ny = edge_cross(y0, y1 - y0, nx - x0, x1 - x0);
            end
            if (co == c0)
            begin
                x0 = nx;
                y0 = ny;
                c0 = region_code(x0, y0);
            end
            else
            begin
                x1 = nx;
                y1 = ny;
                c1 = region_code(x1, y1);
            end
        end
        r.acc = acc;
        r.x0 = acc ? x0[15:0] : 16'd0;
        r.y0 = acc ? y0[15:0] : 16'd0;
        r.x1 = acc ? x1[15:0] : 16'd0;
        r.y1 = acc ? y1[15:0] : 16'd0;
        return r;
    endfunction

    // result side: random stalls, sampled at the rising edge
    always @(posedge clk)
    begin
        clipped_t got;
        clipped_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.acc = m_axis_tuser;
            got.x0 = m_axis_tdata[15:0];
            got.y0 = m_axis_tdata[31:16];
            got.x1 = m_axis_tdata[47:32];
            got.y1 = m_axis_tdata[63:48];
            if (expected_clips.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result acc=%0b data=%h", got.acc, m_axis_tdata);
            end
            else
            begin
                want = expected_clips.pop_front();
                checked++;
                if (got.acc)
                    accepted_seen++;
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp acc=%0b %0d,%0d %0d,%0d got acc=%0b %0d,%0d %0d,%0d",
                                 want.acc, $signed(want.x0), $signed(want.y0),
                                 $signed(want.x1), $signed(want.y1),
                                 got.acc, $signed(got.x0), $signed(got.y0),
                                 $signed(got.x1), $signed(got.y1));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 7);
    end

    task automatic write_window(logic [1:0] idx, longint value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lsc_pkg::REG_XMIN: win_xmin = longint'($signed(value[15:0]));
            lsc_pkg::REG_YMIN: win_ymin = longint'($signed(value[15:0]));
            lsc_pkg::REG_XMAX: win_xmax = longint'($signed(value[15:0]));
            default:           win_ymax = longint'($signed(value[15:0]));
        endcase
    endtask

    task automatic set_window(longint xmin, longint ymin, longint xmax, longint ymax);
        write_window(lsc_pkg::REG_XMIN, xmin);
        write_window(lsc_pkg::REG_YMIN, ymin);
        write_window(lsc_pkg::REG_XMAX, xmax);
        write_window(lsc_pkg::REG_YMAX, ymax);
    endtask

    task automatic drain();
        while (expected_clips.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // drives one segment; s_axis_tvalid stays high across back-to-back sends but for random idles
    task automatic send_segment(segment_t s, bit typed, clipped_t res);
        clipped_t want;
        if (!quiet_tx && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.y1, s.x1, s.y0, s.x0};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = clip_segment(s);
        if (typed && want != res)
        begin
            mismatches++;
            $display("predictor disagrees with typed row");
        end
        expected_clips.push_back(typed ? res : want);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2400)) - 16'd400;
            default: return ($urandom_range(1) ? 16'h7FFF : 16'h8000) ^ 16'($urandom_range(3));
        endcase
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        int mode;
        mode = $urandom_range(9) < 7 ? 1 : ($urandom_range(4) == 0 ? 2 : 0);
        s.x0 = rand_coord(mode);
        s.y0 = rand_coord(mode);
        s.x1 = rand_coord(mode);
        s.y1 = rand_coord(mode);
        return s;
    endfunction

    row_t     rows[$];
    clipped_t none;
    clipped_t keep;
    segment_t s;

    initial
    begin
        cycles = 0;
        mismatches = 0;
        checked = 0;
        accepted_seen = 0;
        quiet_rx = 0;
        quiet_tx = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        win_xmin = 800;
        win_ymin = 160;
        win_xmax = 1280;
        win_ymax = 640;
        none = '{0, 0, 0, 0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows against the reset window
        rows.push_back('{'{16'd900, 16'd200, 16'd1000, 16'd300}, 1,
                         '{1, 16'd900, 16'd200, 16'd1000, 16'd300}});
        rows.push_back('{'{16'd0, 16'd0, 16'd100, 16'd100}, 1, none});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h7FFF}, 1, none});
        rows.push_back('{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF}, 1, none});
        rows.push_back('{'{16'd800, 16'd160, 16'd1280, 16'd640}, 1,
                         '{1, 16'd800, 16'd160, 16'd1280, 16'd640}});
        rows.push_back('{'{16'd0, 16'd400, 16'd2000, 16'd400}, 1,
                         '{1, 16'd800, 16'd400, 16'd1280, 16'd400}});
        rows.push_back('{'{16'd1000, 16'd0, 16'd1000, 16'd1000}, 1,
                         '{1, 16'd1000, 16'd160, 16'd1000, 16'd640}});
        rows.push_back('{'{16'd0, 16'd0, 16'd2000, 16'd1000}, 0, none});
        rows.push_back('{'{16'd700, 16'd700, 16'd1400, 16'd100}, 0, none});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF}, 0, none});
        rows.push_back('{'{16'd700, 16'd100, 16'd1000, 16'h7FFF}, 0, none});
        rows.push_back('{'{16'd0, 16'd700, 16'd900, 16'd1500}, 0, none});
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed, rows[i].res);
        s_axis_tvalid <= 1'b0;
        drain();

        // inverted window: extrapolation and saturation paths
        set_window(2000, 2000, -2000, -2000);
        for (int i = 0; i < 6; i++)
            send_segment('{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                         0, none);
        send_segment('{16'd0, 16'd0, 16'd10, 16'd0}, 0, none);
        send_segment('{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, 0, none);
        s_axis_tvalid <= 1'b0;
        drain();

        // random phases over several windows, extremes among them
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_window(-32768, -32768, 32767, 32767);
                1: set_window(0, 0, 0, 0);
                2: set_window(800, 160, 1280, 640);
                3: set_window(-400, -300, 1500, 1800);
                default: set_window(32767, 32767, -32768, -32768);
            endcase
            quiet_rx = (ph == 2);
            quiet_tx = (ph == 2);
            for (int i = 0; i < 200; i++)
            begin
                s = rand_segment();
                send_segment(s, 0, none);
                if (i == 100)
                begin
                    // hold off until the block has nothing pending
                    s_axis_tvalid <= 1'b0;
                    while (expected_clips.size() != 0)
                        @(negedge clk);
                end
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        $display("checked %0d clipped segments, %0d accepted, over 7 window settings",
                 checked, accepted_seen);
        if (mismatches == 0 && expected_clips.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
